FILE: src/lr_pkg.sv
package lr_pkg;

  localparam int CoordBits = 12;
  localparam int ErrBits   = CoordBits + 3;
  localparam int PitchBits = 13;
  localparam int AddrBits  = 24;
  localparam int ColorBits = 32;
  localparam int ProdBits  = CoordBits + PitchBits;

  localparam logic [PitchBits-1:0] PitchReset = PitchBits'(1024);

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    logic                 valid_res;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [ColorBits-1:0] color;
    logic                 last;
  } pix_t;

endpackage

FILE: src/line_rasterizer.sv
// Bresenham line stepper for a 32-bit-per-pixel frame buffer.
// Input channel (in_valid/in_ready): in_action = start loads the endpoints
// and color from the same item and yields the first pixel; in_action = step
// yields the next pixel of the active line, or a result with out_valid_res
// low when no line is active.
// Result channel (out_valid/out_ready): exactly one item per input item, in
// order, with coordinates, word address y * pitch + x (mod 2^24), color and
// a last flag on the final pixel.
// cfg_wr_en/cfg_wr_data write the row pitch in words; write only while no
// item is in flight.
// Between input accept and out_valid the item passes two registered
// stages: one stage runs the line stepper, the second forms the address
// with one 12x13 multiply. Throughput is one item per cycle while
// out_ready is high; the stepper update itself is combinational.
// Reset (rst_n low, synchronous) drops any active line, empties both
// stages and sets the pitch to 1024. When out_ready is low the two stages
// fill, then in_ready falls; nothing is lost or repeated.
module line_rasterizer
  import lr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [CoordBits-1:0] in_x_start,
  input  logic [CoordBits-1:0] in_y_start,
  input  logic [CoordBits-1:0] in_x_end,
  input  logic [CoordBits-1:0] in_y_end,
  input  logic [ColorBits-1:0] in_draw_color,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_valid_res,
  output logic [CoordBits-1:0] out_pixel_x,
  output logic [CoordBits-1:0] out_pixel_y,
  output logic [AddrBits-1:0]  out_pixel_addr,
  output logic [ColorBits-1:0] out_pixel_color,
  output logic                 out_last,

  input  logic                 cfg_wr_en,
  input  logic [PitchBits-1:0] cfg_wr_data
);

  logic [PitchBits-1:0] pitch_r;

  logic                        active_r, active_nxt;
  logic [CoordBits-1:0]        cur_x_r, cur_x_nxt;
  logic [CoordBits-1:0]        cur_y_r, cur_y_nxt;
  logic signed [ErrBits-1:0]   err_r, err_nxt;
  logic [CoordBits:0]          tmaj_r, tmaj_nxt;
  logic [CoordBits:0]          tmin_r, tmin_nxt;
  logic [CoordBits-1:0]        steps_r, steps_nxt;
  logic                        major_x_r, major_x_nxt;
  logic                        minor_neg_r, minor_neg_nxt;
  logic [ColorBits-1:0]        color_r, color_nxt;

  logic a_vld_r;
  pix_t a_pix_r, a_pix_nxt;
  logic b_vld_r;
  pix_t b_pix_r;
  logic [AddrBits-1:0] b_addr_r;

  logic a_ready;
  logic in_fire;
  logic [ProdBits-1:0] addr_full;

  logic [CoordBits-1:0]      dx, dy, maj, mnr;
  logic                      shallow;
  logic signed [ErrBits-1:0] tmaj_ext, tmin_ext, err_adj;
  logic                      err_pos;

  assign a_ready  = !b_vld_r || out_ready;
  assign in_ready = !a_vld_r || a_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    active_nxt    = active_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    tmaj_nxt      = tmaj_r;
    tmin_nxt      = tmin_r;
    steps_nxt     = steps_r;
    major_x_nxt   = major_x_r;
    minor_neg_nxt = minor_neg_r;
    color_nxt     = color_r;
    a_pix_nxt     = '0;

    dx = (in_x_start > in_x_end) ? in_x_start - in_x_end : in_x_end - in_x_start;
    dy = (in_y_start > in_y_end) ? in_y_start - in_y_end : in_y_end - in_y_start;
    shallow = dx >= dy;
    maj = shallow ? dx : dy;
    mnr = shallow ? dy : dx;

    tmaj_ext = $signed({2'b00, tmaj_r});
    tmin_ext = $signed({2'b00, tmin_r});
    err_pos  = !err_r[ErrBits-1] && (err_r != '0);
    err_adj  = err_pos ? err_r - tmaj_ext : err_r;

    if (action_t'(in_action) == ACT_START) begin
      major_x_nxt = shallow;
      if (shallow) begin
        if (in_x_start <= in_x_end) begin
          cur_x_nxt     = in_x_start;
          cur_y_nxt     = in_y_start;
          minor_neg_nxt = in_y_end < in_y_start;
        end else begin
          cur_x_nxt     = in_x_end;
          cur_y_nxt     = in_y_end;
          minor_neg_nxt = in_y_start < in_y_end;
        end
      end else begin
        if (in_y_start <= in_y_end) begin
          cur_x_nxt     = in_x_start;
          cur_y_nxt     = in_y_start;
          minor_neg_nxt = in_x_end < in_x_start;
        end else begin
          cur_x_nxt     = in_x_end;
          cur_y_nxt     = in_y_end;
          minor_neg_nxt = in_x_start < in_x_end;
        end
      end
      tmaj_nxt   = {maj, 1'b0};
      tmin_nxt   = {mnr, 1'b0};
      err_nxt    = $signed({2'b00, mnr, 1'b0}) - $signed({3'b000, maj});
      steps_nxt  = maj;
      color_nxt  = in_draw_color;
      active_nxt = maj != '0;
      a_pix_nxt.valid_res = 1'b1;
      a_pix_nxt.x         = cur_x_nxt;
      a_pix_nxt.y         = cur_y_nxt;
      a_pix_nxt.color     = in_draw_color;
      a_pix_nxt.last      = maj == '0;
    end else if (active_r) begin
      if (err_pos) begin
        if (major_x_r) begin
          cur_y_nxt = minor_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        end else begin
          cur_x_nxt = minor_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
        end
      end
      if (major_x_r) begin
        cur_x_nxt = cur_x_r + 1'b1;
      end else begin
        cur_y_nxt = cur_y_r + 1'b1;
      end
      err_nxt    = err_adj + tmin_ext;
      steps_nxt  = steps_r - 1'b1;
      active_nxt = steps_nxt != '0;
      a_pix_nxt.valid_res = 1'b1;
      a_pix_nxt.x         = cur_x_nxt;
      a_pix_nxt.y         = cur_y_nxt;
      a_pix_nxt.color     = color_r;
      a_pix_nxt.last      = steps_nxt == '0;
    end
  end

  assign addr_full = {{PitchBits{1'b0}}, a_pix_r.y} * {{CoordBits{1'b0}}, pitch_r}
                   + {{PitchBits{1'b0}}, a_pix_r.x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r  <= PitchReset;
      active_r <= 1'b0;
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pitch_r <= cfg_wr_data;
      end
      if (in_ready) begin
        a_vld_r <= in_valid;
      end
      if (in_fire) begin
        active_r <= active_nxt;
      end
      if (a_ready) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      err_r       <= err_nxt;
      tmaj_r      <= tmaj_nxt;
      tmin_r      <= tmin_nxt;
      steps_r     <= steps_nxt;
      major_x_r   <= major_x_nxt;
      minor_neg_r <= minor_neg_nxt;
      color_r     <= color_nxt;
      a_pix_r     <= a_pix_nxt;
    end
    if (a_vld_r && a_ready) begin
      b_pix_r  <= a_pix_r;
      b_addr_r <= AddrBits'(addr_full);
    end
  end

  assign out_valid       = b_vld_r;
  assign out_valid_res   = b_pix_r.valid_res;
  assign out_pixel_x     = b_pix_r.x;
  assign out_pixel_y     = b_pix_r.y;
  assign out_pixel_addr  = b_addr_r;
  assign out_pixel_color = b_pix_r.color;
  assign out_last        = b_pix_r.last;

  a_active_steps: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> steps_r != '0)
    else $error("active line with no steps left");

  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (action_t'(in_action) == ACT_STEP) && !active_r
      |=> a_vld_r && !a_pix_r.valid_res)
    else $error("step while idle produced a pixel");

  a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (action_t'(in_action) == ACT_START)
      |=> a_vld_r && a_pix_r.valid_res && (a_pix_r.last == !active_r))
    else $error("start item did not yield its first pixel");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && active_r && (action_t'(in_action) == ACT_STEP) && (steps_r == 1)
      |=> !active_r && a_pix_r.last)
    else $error("final step did not end the line");

endmodule
